// ===== sv/sdasm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the signed decimal add/sub/mul block.
// Used by the channel interfaces and the top level; depends on nothing.
package sdasm_pkg;

   localparam int SampleWidth = 10;
   localparam int DigitWidth  = 4;
   localparam int CmdWidth    = 2;
   localparam int MagWidth    = 20;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [SampleWidth-1:0] OffsetReset = 10'd511;

   // register index of input_offset
   localparam logic [0:0] RegInputOffset = 1'b0;

   // magnitudes are shown modulo one million
   localparam logic [MagWidth-1:0] Million = 20'd1000000;

   // x / 1000 == (x * RecipThousand) >> RecipShift for x below one million
   localparam int RecipShift = 30;
   localparam logic [20:0] RecipThousand = 21'd1073742;

   typedef enum logic [CmdWidth-1:0] {
      CMD_NONE = 2'd0,
      CMD_ADD  = 2'd1,
      CMD_SUB  = 2'd2,
      CMD_MUL  = 2'd3
   } cmd_type;

   typedef logic [DigitWidth-1:0] digit_type;

   typedef struct packed {
      digit_type hundreds;
      digit_type tens;
      digit_type ones;
   } digits3_type;

   // Split a value below 1000 into three decimal digits.
   // x / 100 == (x * 41) >> 12 and y / 10 == (y * 205) >> 11 in these ranges.
   function automatic digits3_type split3(input logic [9:0] x);
      logic [15:0]  h_prod;
      logic [3:0]   h;
      logic [9:0]   rem;
      logic [14:0]  t_prod;
      logic [3:0]   t;
      logic [6:0]   rem7;
      digits3_type  d;
      h_prod = {6'd0, x} * 16'd41;
      h      = h_prod[15:12];
      rem    = x - ({6'd0, h} * 10'd100);
      rem7   = rem[6:0];
      t_prod = {8'd0, rem7} * 15'd205;
      t      = t_prod[14:11];
      d.hundreds = h;
      d.tens     = t;
      d.ones     = 4'(rem7 - ({3'd0, t} * 7'd10));
      return d;
   endfunction

endpackage

// ===== sv/sdasm_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: two raw samples and a command, valid/ready handshake.
// Depends on sdasm_pkg.
interface sdasm_req_if;
   import sdasm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SampleWidth-1:0] raw_a;
   logic [SampleWidth-1:0] raw_b;
   logic [CmdWidth-1:0]    command;

   modport source (output valid, raw_a, raw_b, command, input ready);
   modport sink   (input valid, raw_a, raw_b, command, output ready);
endinterface

// ===== sv/sdasm_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: sign, blank flag and six decimal digits, valid/ready.
// Depends on sdasm_pkg.
interface sdasm_rsp_if;
   import sdasm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  blank;
   logic                  negative;
   logic [DigitWidth-1:0] digit5;
   logic [DigitWidth-1:0] digit4;
   logic [DigitWidth-1:0] digit3;
   logic [DigitWidth-1:0] digit2;
   logic [DigitWidth-1:0] digit1;
   logic [DigitWidth-1:0] digit0;

   modport source (output valid, blank, negative, digit5, digit4, digit3, digit2,
                   digit1, digit0, input ready);
   modport sink   (input valid, blank, negative, digit5, digit4, digit3, digit2,
                   digit1, digit0, output ready);
endinterface

// ===== sv/signed_decimal_add_sub_mul.sv =====
`timescale 1ns / 1ps
// Signed decimal add/sub/mul: six-stage pipeline from raw samples to digits.
// Depends on sdasm_pkg, sdasm_req_if and sdasm_rsp_if.
//
// Each request beat carries two raw 10-bit samples; input_offset is taken off
// both to give signed operands, which are added, subtracted (a - b) or
// multiplied. The response beat gives a sign flag and six decimal digits of
// the magnitude (modulo one million), leading zeros kept; zero is never
// negative, and the none command gives a blank beat with all digits zero.
// One beat is taken every cycle unless back pressure has filled the pipeline; the stages are
// offset/add, 10x10 multiply, modulo-million, reciprocal multiply by 1/1000,
// remainder, digit split. Back pressure stalls only the output register and the full
// stages right behind it, so bubbles are squeezed out while rsp waits.
// input_offset sits at byte address 0 of the APB port and resets to 511.
module signed_decimal_add_sub_mul (
   input  logic                              clock,
   input  logic                              reset,
   sdasm_req_if.sink                         req_bus,
   sdasm_rsp_if.source                       rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sdasm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [sdasm_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [sdasm_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                              csr_pready
);
   import sdasm_pkg::*;

   localparam int NumStages = 6;

   // ---------------------------------------------------------------- CSR
   logic [SampleWidth-1:0] offset_ff;
   logic                   csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OffsetReset;
      end else if (csr_wr && (csr_paddr[2] == RegInputOffset)) begin
         offset_ff <= csr_pwdata[SampleWidth-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == RegInputOffset) begin
         csr_prdata = {{(CsrDataWidth-SampleWidth){1'b0}}, offset_ff};
      end
   end

   // ---------------------------------------------------------------- flow control
   // stage k loads when it is empty or its beat moves on this cycle
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] load;

   always_comb begin
      load[NumStages-1] = !vld_ff[NumStages-1] || rsp_bus.ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   assign req_bus.ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) begin
            vld_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (load[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   // centre both samples, take magnitudes, do add/sub
   cmd_type     cmd;
   logic [10:0] a_c;
   logic [10:0] b_c;
   logic [10:0] a_abs;
   logic [10:0] b_abs;
   logic [11:0] sum_c;
   logic [11:0] sum_abs;
   logic        s1_blank_in, s1_neg_in, s1_mul_in;
   logic [10:0] s1_sum_in;

   logic        s1_blank_ff, s1_neg_ff, s1_mul_ff;
   logic [9:0]  s1_ma_ff, s1_mb_ff;
   logic [10:0] s1_sum_ff;

   always_comb begin
      cmd     = cmd_type'(req_bus.command);
      a_c     = {1'b0, req_bus.raw_a} - {1'b0, offset_ff};
      b_c     = {1'b0, req_bus.raw_b} - {1'b0, offset_ff};
      a_abs   = a_c[10] ? (~a_c + 11'd1) : a_c;
      b_abs   = b_c[10] ? (~b_c + 11'd1) : b_c;
      sum_c   = (cmd == CMD_SUB) ? ({a_c[10], a_c} - {b_c[10], b_c})
                                 : ({a_c[10], a_c} + {b_c[10], b_c});
      sum_abs = sum_c[11] ? (~sum_c + 12'd1) : sum_c;

      s1_blank_in = 1'b0;
      s1_neg_in   = 1'b0;
      s1_mul_in   = 1'b0;
      s1_sum_in   = '0;
      case (cmd)
         CMD_NONE: begin
            s1_blank_in = 1'b1;
         end
         CMD_ADD, CMD_SUB: begin
            s1_neg_in = sum_c[11];
            s1_sum_in = sum_abs[10:0];
         end
         CMD_MUL: begin
            s1_mul_in = 1'b1;
            s1_neg_in = a_c[10] ^ b_c[10];
         end
         default: begin
            s1_blank_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_blank_ff <= s1_blank_in;
         s1_neg_ff   <= s1_neg_in;
         s1_mul_ff   <= s1_mul_in;
         s1_ma_ff    <= a_abs[9:0];
         s1_mb_ff    <= b_abs[9:0];
         s1_sum_ff   <= s1_sum_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // product of magnitudes, or the add/sub magnitude
   logic [MagWidth-1:0] s2_mag_in;
   logic [MagWidth-1:0] s2_mag_ff;
   logic                s2_blank_ff, s2_neg_ff;

   assign s2_mag_in = s1_mul_ff ? ({10'd0, s1_ma_ff} * {10'd0, s1_mb_ff})
                                : {9'd0, s1_sum_ff};

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_mag_ff   <= s2_mag_in;
         s2_blank_ff <= s1_blank_ff;
         s2_neg_ff   <= s1_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // drop the carry past six digits; zero shows as positive
   logic [MagWidth-1:0] s3_mag_in;
   logic [MagWidth-1:0] s3_mag_ff;
   logic                s3_blank_ff, s3_neg_ff;

   assign s3_mag_in = (s2_mag_ff >= Million) ? (s2_mag_ff - Million) : s2_mag_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_mag_ff   <= s3_mag_in;
         s3_blank_ff <= s2_blank_ff;
         s3_neg_ff   <= s2_neg_ff && (s3_mag_in != '0);
      end
   end

   // ---------------------------------------------------------------- stage 4
   // upper three digits: magnitude / 1000 by reciprocal
   logic [40:0]         q_prod;
   logic [9:0]          s4_hi_ff;
   logic [MagWidth-1:0] s4_mag_ff;
   logic                s4_blank_ff, s4_neg_ff;

   assign q_prod = {21'd0, s3_mag_ff} * {20'd0, RecipThousand};

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_hi_ff    <= q_prod[RecipShift+9:RecipShift];
         s4_mag_ff   <= s3_mag_ff;
         s4_blank_ff <= s3_blank_ff;
         s4_neg_ff   <= s3_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // lower three digits: remainder after the thousands
   logic [MagWidth-1:0] lo_full;
   logic [9:0]          s5_hi_ff, s5_lo_ff;
   logic                s5_blank_ff, s5_neg_ff;

   assign lo_full = s4_mag_ff - ({10'd0, s4_hi_ff} * 20'd1000);

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_hi_ff    <= s4_hi_ff;
         s5_lo_ff    <= lo_full[9:0];
         s5_blank_ff <= s4_blank_ff;
         s5_neg_ff   <= s4_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   // digit split into the output register
   digits3_type hi_dig, lo_dig;
   digits3_type s6_hi_ff, s6_lo_ff;
   logic        s6_blank_ff, s6_neg_ff;

   assign hi_dig = split3(s5_hi_ff);
   assign lo_dig = split3(s5_lo_ff);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s6_hi_ff    <= hi_dig;
         s6_lo_ff    <= lo_dig;
         s6_blank_ff <= s5_blank_ff;
         s6_neg_ff   <= s5_neg_ff;
      end
   end

   assign rsp_bus.valid    = vld_ff[NumStages-1];
   assign rsp_bus.blank    = s6_blank_ff;
   assign rsp_bus.negative = s6_neg_ff;
   assign rsp_bus.digit5   = s6_hi_ff.hundreds;
   assign rsp_bus.digit4   = s6_hi_ff.tens;
   assign rsp_bus.digit3   = s6_hi_ff.ones;
   assign rsp_bus.digit2   = s6_lo_ff.hundreds;
   assign rsp_bus.digit1   = s6_lo_ff.tens;
   assign rsp_bus.digit0   = s6_lo_ff.ones;

endmodule
